>>> sv/rtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_pkg: shared types for the range table merge and match block
// Item kinds, status codes, sequencer states and the stored range entry.
// ----------------------------------------------------------------------------
package rtm_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD     = 2'd0,
    KIND_FINALIZE = 2'd1,
    KIND_QUERY    = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_REVERSED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QUERY,
    S_RDKEY,
    S_GETKEY,
    S_CMP,
    S_PUT,
    S_MSTART,
    S_MHEAD,
    S_MRUN,
    S_MFLUSH,
    S_MDRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [63:0] first_id;
    logic [63:0] last_id;
  } entry_t;

endpackage

>>> sv/rtm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_in_if / rtm_out_if: valid-ready channels of the range table
// Input carries the item kind and its operands, output carries one result.
// ----------------------------------------------------------------------------
interface rtm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] range_start;
  logic [63:0] range_end;
  logic [63:0] query_id;

  modport source (output valid, kind, range_start, range_end, query_id, input ready);
  modport sink   (input valid, kind, range_start, range_end, query_id, output ready);
endinterface

interface rtm_out_if #(
  parameter int CNT_W = 9
);
  logic             valid;
  logic             ready;
  logic             is_member;
  logic [63:0]      covered_total;
  logic [CNT_W-1:0] entries_held;
  logic [1:0]       status;

  modport source (output valid, is_member, covered_total, entries_held, status, input ready);
  modport sink   (input valid, is_member, covered_total, entries_held, status, output ready);
endinterface

>>> sv/rtm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rtm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/range_table_merge_and_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_table_merge_and_match: table of inclusive 64-bit ranges
// Load, finalize (sort, merge, count), query and clear under one sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one item per transaction (kind and operands); out_o returns
//   exactly one result transaction per item, in order. in_i.ready is high only
//   while the sequencer is idle; one item is worked on at a time.
// Work done per item:
//   query             : one RAM read per stored range, pipelined
//   finalize          : insertion sort moves one entry per cycle (read the
//                       next slot while writing the current one), then the
//                       merge walks the table once while a saturating 65-bit
//                       adder accumulates each span.
// The range bounds live in one RAM (one read, one write port); no clearing
// pass is needed since only entries below the count are ever read.
// Reset empties the table and drops any pending result.
// When out_o stalls, the finished result holds in the output register; the
// sequencer may take one more item, then waits with its result until the
// held one has been delivered.
// ----------------------------------------------------------------------------
module range_table_merge_and_match #(
  parameter int MAX_RANGES = 256
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  rtm_in_if.sink  in_i,
  rtm_out_if.source out_o
);

  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int AW = $clog2(MAX_RANGES);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_RANGES);

  rtm_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]    i_q, i_d;
  logic [AW-1:0]    j_q, j_d;
  logic [AW-1:0]    head_q, head_d;
  rtm_pkg::entry_t  key_q, key_d;
  rtm_pkg::entry_t  hd_q, hd_d;
  logic [63:0]      qid_q, qid_d;
  logic [1:0]       kind_q, kind_d;
  logic             member_q, member_d;
  logic [1:0]       status_q, status_d;
  logic [63:0]      span_q, span_d;
  logic             span_v_q, span_v_d;
  logic [63:0]      sum_q, sum_d;

  logic             out_valid_q, out_valid_d;
  logic             out_member_q, out_member_d;
  logic [63:0]      out_total_q, out_total_d;
  logic [CNT_W-1:0] out_held_q, out_held_d;
  logic [1:0]       out_status_q, out_status_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  rtm_pkg::entry_t  ram_wdata;
  logic [AW-1:0]    ram_raddr;
  rtm_pkg::entry_t  ram_rdata;

  logic [AW-1:0]    i_inc;
  logic             last_i;
  logic [64:0]      acc;

  rtm_ram #(
    .WIDTH($bits(rtm_pkg::entry_t)),
    .DEPTH(MAX_RANGES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_i.ready          = (state_q == rtm_pkg::S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.is_member     = out_member_q;
  assign out_o.covered_total = out_total_q;
  assign out_o.entries_held  = out_held_q;
  assign out_o.status        = out_status_q;

  assign i_inc  = i_q + AW'(1);
  assign last_i = ((CNT_W'(i_q) + CNT_W'(1)) == cnt_q);
  assign acc    = {1'b0, sum_q} + {1'b0, span_q} + 65'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtm_pkg::S_IDLE;
      cnt_q       <= '0;
      span_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      span_v_q    <= span_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    j_q          <= j_d;
    head_q       <= head_d;
    key_q        <= key_d;
    hd_q         <= hd_d;
    qid_q        <= qid_d;
    kind_q       <= kind_d;
    member_q     <= member_d;
    status_q     <= status_d;
    span_q       <= span_d;
    sum_q        <= sum_d;
    out_member_q <= out_member_d;
    out_total_q  <= out_total_d;
    out_held_q   <= out_held_d;
    out_status_q <= out_status_d;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    i_d          = i_q;
    j_d          = j_q;
    head_d       = head_q;
    key_d        = key_q;
    hd_d         = hd_q;
    qid_d        = qid_q;
    kind_d       = kind_q;
    member_d     = member_q;
    status_d     = status_q;
    span_d       = span_q;
    span_v_d     = 1'b0;
    sum_d        = sum_q;
    out_valid_d  = out_valid_q & ~out_o.ready;
    out_member_d = out_member_q;
    out_total_d  = out_total_q;
    out_held_d   = out_held_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = cnt_q[AW-1:0];
    ram_wdata    = key_q;
    ram_raddr    = '0;

    // saturating span accumulator, one merged range per cycle
    if (span_v_q) begin
      sum_d = acc[64] ? '1 : acc[63:0];
    end

    case (state_q)
      rtm_pkg::S_IDLE: begin
        if (in_i.valid) begin
          kind_d   = in_i.kind;
          qid_d    = in_i.query_id;
          member_d = 1'b0;
          status_d = rtm_pkg::ST_OK;
          sum_d    = '0;
          i_d      = '0;
          state_d  = rtm_pkg::S_DONE;
          case (rtm_pkg::kind_e'(in_i.kind))
            rtm_pkg::KIND_LOAD: begin
              if (cnt_q == MaxCnt) begin
                status_d = rtm_pkg::ST_FULL;
              end else if (in_i.range_start > in_i.range_end) begin
                status_d = rtm_pkg::ST_REVERSED;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = '{first_id: in_i.range_start, last_id: in_i.range_end};
                cnt_d     = cnt_q + CNT_W'(1);
              end
            end
            rtm_pkg::KIND_FINALIZE: begin
              i_d = AW'(1);
              if (cnt_q == CNT_W'(1)) begin
                state_d = rtm_pkg::S_MSTART;
              end else if (cnt_q != '0) begin
                state_d = rtm_pkg::S_RDKEY;
              end
            end
            rtm_pkg::KIND_QUERY: begin
              ram_raddr = '0;
              if (cnt_q != '0) begin
                state_d = rtm_pkg::S_QUERY;
              end
            end
            default: begin
              cnt_d = '0;
            end
          endcase
        end
      end

      rtm_pkg::S_QUERY: begin
        // data for entry i arrives while entry i+1 is requested
        if (qid_q >= ram_rdata.first_id && qid_q <= ram_rdata.last_id) begin
          member_d = 1'b1;
        end
        ram_raddr = i_inc;
        i_d       = i_inc;
        if (last_i) begin
          state_d = rtm_pkg::S_DONE;
        end
      end

      rtm_pkg::S_RDKEY: begin
        ram_raddr = i_q;
        state_d   = rtm_pkg::S_GETKEY;
      end

      rtm_pkg::S_GETKEY: begin
        key_d     = ram_rdata;
        j_d       = i_q;
        ram_raddr = i_q - AW'(1);
        state_d   = rtm_pkg::S_CMP;
      end

      rtm_pkg::S_CMP: begin
        ram_waddr = j_q;
        ram_we    = 1'b1;
        if (ram_rdata.first_id > key_q.first_id) begin
          // shift the larger entry up one slot
          ram_wdata = ram_rdata;
          j_d       = j_q - AW'(1);
          ram_raddr = j_q - AW'(2);
          if (j_q == AW'(1)) begin
            state_d = rtm_pkg::S_PUT;
          end
        end else begin
          ram_wdata = key_q;
          i_d       = i_inc;
          state_d   = last_i ? rtm_pkg::S_MSTART : rtm_pkg::S_RDKEY;
        end
      end

      rtm_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = key_q;
        i_d       = i_inc;
        state_d   = last_i ? rtm_pkg::S_MSTART : rtm_pkg::S_RDKEY;
      end

      rtm_pkg::S_MSTART: begin
        ram_raddr = '0;
        state_d   = rtm_pkg::S_MHEAD;
      end

      rtm_pkg::S_MHEAD: begin
        hd_d      = ram_rdata;
        head_d    = '0;
        i_d       = AW'(1);
        ram_raddr = AW'(1);
        state_d   = (cnt_q == CNT_W'(1)) ? rtm_pkg::S_MFLUSH : rtm_pkg::S_MRUN;
      end

      rtm_pkg::S_MRUN: begin
        if (ram_rdata.first_id <= hd_q.last_id) begin
          if (ram_rdata.last_id > hd_q.last_id) begin
            hd_d.last_id = ram_rdata.last_id;
          end
        end else begin
          // close the current head and open a new one
          ram_we    = 1'b1;
          ram_waddr = head_q;
          ram_wdata = hd_q;
          span_d    = hd_q.last_id - hd_q.first_id;
          span_v_d  = 1'b1;
          head_d    = head_q + AW'(1);
          hd_d      = ram_rdata;
        end
        ram_raddr = i_inc;
        i_d       = i_inc;
        if (last_i) begin
          state_d = rtm_pkg::S_MFLUSH;
        end
      end

      rtm_pkg::S_MFLUSH: begin
        ram_we    = 1'b1;
        ram_waddr = head_q;
        ram_wdata = hd_q;
        span_d    = hd_q.last_id - hd_q.first_id;
        span_v_d  = 1'b1;
        cnt_d     = CNT_W'(head_q) + CNT_W'(1);
        state_d   = rtm_pkg::S_MDRAIN;
      end

      rtm_pkg::S_MDRAIN: begin
        state_d = rtm_pkg::S_DONE;
      end

      rtm_pkg::S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_member_d = member_q;
          out_total_d  = (kind_q == rtm_pkg::KIND_FINALIZE) ? sum_q : '0;
          out_held_d   = cnt_q;
          out_status_d = status_q;
          state_d      = rtm_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rtm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/rtm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_checker: port-level checks for the range table block
// Watches both channels and the result fields over time.
// ----------------------------------------------------------------------------
module rtm_checker #(
  parameter int MAX_RANGES = 256,
  parameter int CNT_W      = 9
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             is_member_i,
  input logic [63:0]      covered_total_i,
  input logic [CNT_W-1:0] entries_held_i,
  input logic [1:0]       status_i
);

  // a result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // one item at a time: no back-to-back acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> entries_held_i <= CNT_W'(MAX_RANGES))
    else $error("entry count beyond table depth");

  // a result belongs to one kind only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (is_member_i || status_i != rtm_pkg::ST_OK) |-> covered_total_i == 64'd0)
    else $error("total reported on a non-finalize result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != rtm_pkg::ST_OK |-> !is_member_i)
    else $error("membership reported on a load result");

endmodule

bind range_table_merge_and_match rtm_checker #(
  .MAX_RANGES(MAX_RANGES),
  .CNT_W     (CNT_W)
) u_rtm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .is_member_i    (out_o.is_member),
  .covered_total_i(out_o.covered_total),
  .entries_held_i (out_o.entries_held),
  .status_i       (out_o.status)
);

>>> bench/tb_range_table_merge_and_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_table_merge_and_match: self-checking bench for the range table
// Drives load, finalize, query and clear transactions with random gaps on
// both channels, predicts every result in a scoreboard and compares each
// delivered result field by field, in order.
// ----------------------------------------------------------------------------
module tb_range_table_merge_and_match;

  localparam int TABLE_DEPTH = 256;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic        is_member;
    logic [63:0] covered_total;
    logic [8:0]  entries_held;
    logic [1:0]  status;
  } result_t;

  class range_scoreboard;
    logic [63:0] starts[TABLE_DEPTH];
    logic [63:0] ends[TABLE_DEPTH];
    int          count;
    result_t     awaited[$];
    int          mismatches;

    function new();
      count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // insertion sort by start, then merge overlapping ranges in place
    function void sort_and_merge();
      logic [63:0] ks, ke;
      int j, head;
      for (int i = 1; i < count; i++) begin
        ks = starts[i];
        ke = ends[i];
        j = i;
        while (j > 0 && starts[j-1] > ks) begin
          starts[j] = starts[j-1];
          ends[j] = ends[j-1];
          j--;
        end
        starts[j] = ks;
        ends[j] = ke;
      end
      if (count == 0) return;
      head = 0;
      for (int i = 1; i < count; i++) begin
        if (starts[i] <= ends[head]) begin
          if (ends[i] > ends[head]) ends[head] = ends[i];
        end else begin
          head++;
          starts[head] = starts[i];
          ends[head] = ends[i];
        end
      end
      count = head + 1;
    endfunction

    function logic [63:0] covered_sum();
      logic [64:0] sum;
      logic [63:0] span;
      sum = '0;
      for (int i = 0; i < count; i++) begin
        span = ends[i] - starts[i];
        if (span == ALL_ONES) return ALL_ONES;
        sum = sum + {1'b0, span} + 65'd1;
        if (sum > {1'b0, ALL_ONES}) return ALL_ONES;
      end
      return sum[63:0];
    endfunction

    function void note_item(rtm_pkg::kind_e k, logic [63:0] s, logic [63:0] e,
                            logic [63:0] q);
      result_t r;
      r.is_member = 1'b0;
      r.covered_total = '0;
      r.status = rtm_pkg::ST_OK;
      case (k)
        rtm_pkg::KIND_LOAD: begin
          if (count >= TABLE_DEPTH) r.status = rtm_pkg::ST_FULL;
          else if (s > e) r.status = rtm_pkg::ST_REVERSED;
          else begin
            starts[count] = s;
            ends[count] = e;
            count++;
          end
        end
        rtm_pkg::KIND_FINALIZE: begin
          sort_and_merge();
          r.covered_total = covered_sum();
        end
        rtm_pkg::KIND_QUERY: begin
          for (int i = 0; i < count; i++)
            if (q >= starts[i] && q <= ends[i]) r.is_member = 1'b1;
        end
        default: count = 0;
      endcase
      r.entries_held = count[8:0];
      awaited.push_back(r);
    endfunction

    function void check_result(logic m, logic [63:0] t, logic [8:0] h, logic [1:0] st);
      result_t x;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result m=%0b t=%0h h=%0d st=%0d", m, t, h, st);
        return;
      end
      x = awaited.pop_front();
      if (m !== x.is_member || t !== x.covered_total || h !== x.entries_held
          || st !== x.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp m=%0b t=%0h h=%0d st=%0d, got m=%0b t=%0h h=%0d st=%0d",
                   x.is_member, x.covered_total, x.entries_held, x.status, m, t, h, st);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  rtm_in_if in_if ();
  rtm_out_if #(.CNT_W(9)) out_if ();

  range_table_merge_and_match #(.MAX_RANGES(TABLE_DEPTH)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  range_scoreboard sb = new();
  int  items_sent = 0;
  bit  no_idle = 1'b0;
  bit  stim_done = 1'b0;

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = rtm_pkg::KIND_CLEAR;
    in_if.range_start = '0;
    in_if.range_end = '0;
    in_if.query_id = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      sb.note_item(rtm_pkg::kind_e'(in_if.kind), in_if.range_start, in_if.range_end,
                   in_if.query_id);
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.is_member, out_if.covered_total, out_if.entries_held,
                      out_if.status);
  end

  // result side: random stall before each transaction
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = no_idle ? 0 : int'($urandom_range(0, 16));
      if (gap > 0) begin
        out_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send(rtm_pkg::kind_e k, logic [63:0] s, logic [63:0] e, logic [63:0] q);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 16));
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.kind = k;
    in_if.range_start = s;
    in_if.range_end = e;
    in_if.query_id = q;
    in_if.valid = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic load_random();
    logic [63:0] s, e, t;
    int mode;
    mode = int'($urandom_range(0, 19));
    if (mode < 10) begin
      s = 64'($urandom_range(0, 2000));
      e = s + 64'($urandom_range(0, 60));
    end else if (mode < 14) begin
      s = rand64();
      e = rand64();
      if (s > e) begin t = s; s = e; e = t; end
    end else if (mode < 16) begin
      s = ALL_ONES - 64'($urandom_range(0, 40));
      e = ALL_ONES - 64'($urandom_range(0, 3));
      if (s > e) s = e;
    end else if (mode < 18) begin
      s = 64'($urandom_range(0, 3));
      e = $urandom_range(0, 1) ? ALL_ONES : s + 64'($urandom_range(0, 9));
    end else begin
      e = 64'($urandom_range(0, 2000));
      s = e + 64'($urandom_range(1, 50));
    end
    send(rtm_pkg::KIND_LOAD, s, e, rand64());
  endtask

  task automatic query_random();
    logic [63:0] q;
    int idx;
    if (sb.count > 0 && $urandom_range(0, 4) != 0) begin
      idx = int'($urandom_range(0, sb.count - 1));
      case ($urandom_range(0, 4))
        0: q = sb.starts[idx] - 64'd1;
        1: q = sb.starts[idx];
        2: q = sb.ends[idx];
        3: q = sb.ends[idx] + 64'd1;
        default: q = sb.starts[idx] + (sb.ends[idx] - sb.starts[idx]) / 64'd2;
      endcase
    end else begin
      q = $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 2100));
    end
    send(rtm_pkg::KIND_QUERY, rand64(), rand64(), q);
  endtask

  initial begin
    int n;
    bit full_done, pause_done;
    full_done = 1'b0;
    pause_done = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    send(rtm_pkg::KIND_QUERY, '0, '0, '0);
    send(rtm_pkg::KIND_FINALIZE, '0, '0, '0);
    send(rtm_pkg::KIND_LOAD, '0, ALL_ONES, '0);
    send(rtm_pkg::KIND_QUERY, '0, '0, ALL_ONES);
    send(rtm_pkg::KIND_FINALIZE, '0, '0, '0);
    send(rtm_pkg::KIND_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES);
    send(rtm_pkg::KIND_LOAD, 64'd1, 64'd0, '0);
    send(rtm_pkg::KIND_LOAD, ALL_ONES, ALL_ONES, '0);
    send(rtm_pkg::KIND_LOAD, '0, '0, '0);
    send(rtm_pkg::KIND_LOAD, ALL_ONES - 1, ALL_ONES, '0);
    send(rtm_pkg::KIND_FINALIZE, '0, '0, '0);
    send(rtm_pkg::KIND_LOAD, 64'd10, 64'd20, '0);
    send(rtm_pkg::KIND_LOAD, 64'd5, 64'd9, '0);
    send(rtm_pkg::KIND_LOAD, 64'd100, 64'd200, '0);
    send(rtm_pkg::KIND_LOAD, 64'd100, 64'd150, '0);
    send(rtm_pkg::KIND_LOAD, 64'd150, 64'd300, '0);
    send(rtm_pkg::KIND_FINALIZE, '0, '0, '0);
    send(rtm_pkg::KIND_QUERY, '0, '0, 64'd4);
    send(rtm_pkg::KIND_QUERY, '0, '0, 64'd9);
    send(rtm_pkg::KIND_QUERY, '0, '0, 64'd300);
    send(rtm_pkg::KIND_QUERY, '0, '0, 64'd301);
    send(rtm_pkg::KIND_LOAD, 64'd1, 64'd3, '0);
    send(rtm_pkg::KIND_QUERY, '0, '0, 64'd2);
    send(rtm_pkg::KIND_FINALIZE, '0, '0, '0);
    send(rtm_pkg::KIND_CLEAR, '0, '0, '0);

    while (items_sent < 1700) begin
      if ($urandom_range(0, 4) == 0) no_idle = ~no_idle;
      if (!pause_done && items_sent > 600) begin
        // let every result drain before going on
        in_if.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
        pause_done = 1'b1;
      end
      if (!full_done && items_sent > 900) begin
        // fill the table, then push past the limit
        send(rtm_pkg::KIND_CLEAR, '0, '0, '0);
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
          send(rtm_pkg::KIND_LOAD, 64'(i) * 64'd7,
               64'(i) * 64'd7 + 64'($urandom_range(0, 9)), '0);
        send(rtm_pkg::KIND_LOAD, 64'd9, 64'd1, '0);
        query_random();
        send(rtm_pkg::KIND_FINALIZE, '0, '0, '0);
        full_done = 1'b1;
      end
      if ($urandom_range(0, 6) == 0) begin
        // noise: any kind, any field values
        n = int'($urandom_range(1, 6));
        for (int i = 0; i < n; i++)
          send(rtm_pkg::kind_e'(2'($urandom_range(0, 3))), rand64(), rand64(), rand64());
      end else begin
        if (sb.count > 40 || $urandom_range(0, 9) < 7)
          send(rtm_pkg::KIND_CLEAR, rand64(), rand64(), rand64());
        n = int'($urandom_range(0, 10));
        for (int i = 0; i < n; i++) load_random();
        n = int'($urandom_range(0, 4));
        for (int i = 0; i < n; i++) query_random();
        send(rtm_pkg::KIND_FINALIZE, rand64(), rand64(), rand64());
        n = int'($urandom_range(0, 8));
        for (int i = 0; i < n; i++) query_random();
        if ($urandom_range(0, 3) == 0) begin
          load_random();
          query_random();
          send(rtm_pkg::KIND_FINALIZE, '0, '0, '0);
        end
      end
    end
    in_if.valid = 1'b0;
    no_idle = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[range_table_merge_and_match] OK");
    end else begin
      $display("[range_table_merge_and_match] ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("[range_table_merge_and_match] ERROR");
    $finish;
  end

endmodule
